FILE: rtl/rjhg_pkg.sv
`default_nettype none
package rjhg_pkg;

  localparam int unsigned HDR_BASE_LEN = 605;
  localparam int unsigned DRI_LEN      = 6;

  typedef enum logic [2:0] {
    REG_QUALITY  = 3'd0,
    REG_TYPE     = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_RESTART  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul_en;
    logic div_en;
  } cmd_t;

  // 5000/f for f below 50, entry zero unused
  localparam logic [12:0] SCALE_LOW [0:49] = '{
    13'd5000, 13'd5000, 13'd2500, 13'd1666, 13'd1250, 13'd1000, 13'd833, 13'd714,
    13'd625, 13'd555, 13'd500, 13'd454, 13'd416, 13'd384, 13'd357, 13'd333,
    13'd312, 13'd294, 13'd277, 13'd263, 13'd250, 13'd238, 13'd227, 13'd217,
    13'd208, 13'd200, 13'd192, 13'd185, 13'd178, 13'd172, 13'd166, 13'd161,
    13'd156, 13'd151, 13'd147, 13'd142, 13'd138, 13'd135, 13'd131, 13'd128,
    13'd125, 13'd121, 13'd119, 13'd116, 13'd113, 13'd111, 13'd108, 13'd106,
    13'd104, 13'd102
  };

  localparam logic [6:0] LUMA_BASE [0:63] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  localparam logic [6:0] CHROMA_BASE [0:63] = '{
    7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
  };

  localparam logic [5:0] ZIGZAG [0:63] = '{
    6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  localparam logic [7:0] DHT_BITS [0:63] = '{
    8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
    8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d,
    8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
    8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77
  };

  localparam logic [7:0] AC_LUMA [0:161] = '{
    8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12,
    8'h21, 8'h31, 8'h41, 8'h06, 8'h13, 8'h51, 8'h61, 8'h07,
    8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08,
    8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0,
    8'h24, 8'h33, 8'h62, 8'h72, 8'h82, 8'h09, 8'h0a, 8'h16,
    8'h17, 8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
    8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
    8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79,
    8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98,
    8'h99, 8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7,
    8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6,
    8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5,
    8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4,
    8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2,
    8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea,
    8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8,
    8'hf9, 8'hfa
  };

  localparam logic [7:0] AC_CHROMA [0:161] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h05, 8'h21,
    8'h31, 8'h06, 8'h12, 8'h41, 8'h51, 8'h07, 8'h61, 8'h71,
    8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14, 8'h42, 8'h91,
    8'ha1, 8'hb1, 8'hc1, 8'h09, 8'h23, 8'h33, 8'h52, 8'hf0,
    8'h15, 8'h62, 8'h72, 8'hd1, 8'h0a, 8'h16, 8'h24, 8'h34,
    8'he1, 8'h25, 8'hf1, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h2a, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h3a, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
    8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
    8'h59, 8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68,
    8'h69, 8'h6a, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
    8'h79, 8'h7a, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h88, 8'h89, 8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96,
    8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3, 8'ha4, 8'ha5,
    8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4,
    8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3,
    8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9, 8'hca, 8'hd2,
    8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda,
    8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9,
    8'hea, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8,
    8'hf9, 8'hfa
  };

  localparam logic [7:0] SOS_BYTES [0:13] = '{
    8'hff, 8'hda, 8'h00, 8'h0c, 8'h03, 8'h00, 8'h00, 8'h01,
    8'h11, 8'h02, 8'h11, 8'h00, 8'h3f, 8'h00
  };

endpackage
`default_nettype wire

FILE: rtl/rjhg_ctrl.sv
`default_nettype none
module rjhg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output rjhg_pkg::cmd_t     cmd
);
  import rjhg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/rjhg_datapath.sv
`default_nettype none
module rjhg_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rjhg_pkg::cmd_t cmd,
  input  wire logic          restart,
  input  wire logic          cfg_wr_en,
  input  wire logic [2:0]    cfg_addr,
  input  wire logic [15:0]   cfg_wdata,
  output logic [7:0]         header_byte,
  output logic [9:0]         byte_offset,
  output logic               last
);
  import rjhg_pkg::*;

  logic [7:0]  quality_r, type_r, width_r, height_r;
  logic [15:0] rst_intv_r;
  logic [9:0]  pos_r, cur_pos_r;
  logic [12:0] scale_r;
  logic        last_r;
  logic [19:0] prod_r;
  logic        is_quant_r;
  logic [7:0]  const_r;
  logic [7:0]  byte_r;
  logic [9:0]  off_r;
  logic        tlast_r;

  logic        dri;
  logic [9:0]  total;
  logic [9:0]  pos_sel;
  logic [6:0]  qclamp;
  logic [12:0] scale_nxt;

  assign dri   = (rst_intv_r != 16'd0);
  assign total = dri ? 10'(HDR_BASE_LEN + DRI_LEN) : 10'(HDR_BASE_LEN);

  always_comb begin
    pos_sel = (restart || (pos_r >= total)) ? 10'd0 : pos_r;
    if (quality_r == 8'd0) begin
      qclamp = 7'd1;
    end else if (quality_r > 8'd99) begin
      qclamp = 7'd99;
    end else begin
      qclamp = quality_r[6:0];
    end
    if (qclamp < 7'd50) begin
      scale_nxt = SCALE_LOW[qclamp[5:0]];
    end else begin
      scale_nxt = 13'd200 - {5'd0, qclamp, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quality_r  <= 8'd50;
      type_r     <= 8'd0;
      width_r    <= 8'd0;
      height_r   <= 8'd0;
      rst_intv_r <= 16'd0;
      pos_r      <= 10'd0;
      scale_r    <= 13'd0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          REG_QUALITY: quality_r  <= cfg_wdata[7:0];
          REG_TYPE:    type_r     <= cfg_wdata[7:0];
          REG_WIDTH:   width_r    <= cfg_wdata[7:0];
          REG_HEIGHT:  height_r   <= cfg_wdata[7:0];
          REG_RESTART: rst_intv_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        pos_r <= pos_sel + 10'd1;
        if (pos_sel == 10'd0) begin
          scale_r <= scale_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_pos_r <= pos_sel;
      last_r    <= (pos_sel == total - 10'd1);
    end
  end

  // byte decode for the current offset
  logic [9:0]  p, k, q, r, i;
  logic        tsel;
  logic [1:0]  seg;
  logic [6:0]  base;
  logic        is_quant;
  logic [7:0]  cbyte;
  logic [5:0]  zz;
  logic [10:0] hp, wp;

  always_comb begin
    p        = cur_pos_r - 10'd2;
    tsel     = (p >= 10'd69);
    k        = tsel ? p - 10'd69 : p;
    zz       = 6'(k - 10'd5);
    q        = cur_pos_r - 10'd140;
    r        = 10'd0;
    i        = 10'd0;
    seg      = 2'd0;
    is_quant = 1'b0;
    cbyte    = 8'h00;
    base     = tsel ? CHROMA_BASE[ZIGZAG[zz]] : LUMA_BASE[ZIGZAG[zz]];
    hp       = {height_r, 3'b000};
    wp       = {width_r, 3'b000};
    if (cur_pos_r < 10'd2) begin
      cbyte = (cur_pos_r == 10'd0) ? 8'hff : 8'hd8;
    end else if (cur_pos_r < 10'd140) begin
      case (k)
        10'd0:   cbyte = 8'hff;
        10'd1:   cbyte = 8'hdb;
        10'd2:   cbyte = 8'h00;
        10'd3:   cbyte = 8'h43;
        10'd4:   cbyte = {7'd0, tsel};
        default: is_quant = 1'b1;
      endcase
    end else if (dri && (q < 10'd6)) begin
      case (q[2:0])
        3'd0:    cbyte = 8'hff;
        3'd1:    cbyte = 8'hdd;
        3'd2:    cbyte = 8'h00;
        3'd3:    cbyte = 8'h04;
        3'd4:    cbyte = rst_intv_r[15:8];
        default: cbyte = rst_intv_r[7:0];
      endcase
    end else begin
      if (dri) begin
        q = q - 10'd6;
      end
      if (q < 10'd19) begin
        case (q[4:0])
          5'd0:  cbyte = 8'hff;
          5'd1:  cbyte = 8'hc0;
          5'd3:  cbyte = 8'h11;
          5'd4:  cbyte = 8'h08;
          5'd5:  cbyte = {5'd0, hp[10:8]};
          5'd6:  cbyte = hp[7:0];
          5'd7:  cbyte = {5'd0, wp[10:8]};
          5'd8:  cbyte = wp[7:0];
          5'd9:  cbyte = 8'h03;
          5'd11: cbyte = (type_r == 8'd0) ? 8'h21 : 8'h22;
          5'd13: cbyte = 8'h01;
          5'd14: cbyte = 8'h11;
          5'd15: cbyte = 8'h01;
          5'd16: cbyte = 8'h02;
          5'd17: cbyte = 8'h11;
          5'd18: cbyte = 8'h01;
          default: cbyte = 8'h00;
        endcase
      end else begin
        r = q - 10'd19;
        if (r < 10'd432) begin
          if (r < 10'd33) begin
            seg = 2'd0;
            i   = r;
          end else if (r < 10'd216) begin
            seg = 2'd1;
            i   = r - 10'd33;
          end else if (r < 10'd249) begin
            seg = 2'd2;
            i   = r - 10'd216;
          end else begin
            seg = 2'd3;
            i   = r - 10'd249;
          end
          if (i < 10'd5) begin
            case (i[2:0])
              3'd0:    cbyte = 8'hff;
              3'd1:    cbyte = 8'hc4;
              3'd2:    cbyte = 8'h00;
              3'd3:    cbyte = seg[0] ? 8'd181 : 8'd31;
              default: cbyte = {3'd0, seg[0], 3'd0, seg[1]};
            endcase
          end else if (i < 10'd21) begin
            cbyte = DHT_BITS[{seg, 4'(i - 10'd5)}];
          end else if (!seg[0]) begin
            cbyte = 8'(i - 10'd21);
          end else if (seg[1]) begin
            cbyte = AC_CHROMA[8'(i - 10'd21)];
          end else begin
            cbyte = AC_LUMA[8'(i - 10'd21)];
          end
        end else begin
          cbyte = SOS_BYTES[4'(r - 10'd432)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r     <= 20'(base) * 20'(scale_r);
      is_quant_r <= is_quant;
      const_r    <= cbyte;
    end
  end

  // (x+50)/100 by reciprocal, exact below the clamp threshold
  logic [19:0] rnd;
  logic [27:0] recip;
  logic [7:0]  quot;

  always_comb begin
    rnd   = prod_r + 20'd50;
    recip = 28'(rnd[14:0]) * 28'd5243;
    if (rnd >= 20'd25600) begin
      quot = 8'd255;
    end else if (recip[26:19] == 8'd0) begin
      quot = 8'd1;
    end else begin
      quot = recip[26:19];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_en) begin
      byte_r  <= is_quant_r ? quot : const_r;
      off_r   <= cur_pos_r;
      tlast_r <= last_r;
    end
  end

  assign header_byte = byte_r;
  assign byte_offset = off_r;
  assign last        = tlast_r;

endmodule
`default_nettype wire

FILE: rtl/rtp_jpeg_header_generator.sv
`default_nettype none
// rebuilds the jpeg interchange header that rtp/jpeg payloads leave out
// input channel: each beat asks for one header byte; in_tdata[0] = restart
// starts a new header at the soi byte, otherwise the next byte follows
// output channel: one beat per input beat; out_tdata carries the byte and
// its offset, out_tlast marks the final sos byte
// cfg port: write quality, type, width, height and restart interval while
// no beat is in flight; the scale is latched at each offset-zero byte
// the beat's offset, product and result are registered in turn before
// out_tvalid rises; the controller walks accept, multiply, divide-by-100
// and output states and holds one byte at a time, so a new input beat is
// taken only after the last byte is delivered
// reset: position and scale cleared, registers to defaults, no beat held
// receiver stall: the byte is held in the output register and in_tready
// stays low until it is taken
module rtp_jpeg_header_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] header_byte, [17:8] byte_offset
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);
  import rjhg_pkg::*;

  cmd_t       cmd;
  logic [7:0] header_byte;
  logic [9:0] byte_offset;

  rjhg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rjhg_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .restart     (in_tdata[0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .header_byte (header_byte),
    .byte_offset (byte_offset),
    .last        (out_tlast)
  );

  assign out_tdata = {6'd0, byte_offset, header_byte};

endmodule
`default_nettype wire
